[design/tfs_pkg.sv]
// ----------------------------------------------------------------------------
// tfs_pkg
// Shared sizes, operation and status codes, and the controller/datapath
// command and status bundles of the timed FIFO semaphore bank.
// ----------------------------------------------------------------------------
package tfs_pkg;

	localparam int NUM_SEMS    = 4;
	localparam int MAX_WAITERS = 8;
	localparam int TASK_BITS   = 8;
	localparam int TICK_BITS   = 24;
	localparam int ARR_BITS    = 16;
	localparam int SEM_BITS    = $clog2(NUM_SEMS);
	localparam int SLOT_BITS   = $clog2(MAX_WAITERS);
	localparam int WT_BITS     = TICK_BITS + 1;

	// operation codes
	localparam logic [1:0] MODE_INIT    = 2'd0;
	localparam logic [1:0] MODE_ACQUIRE = 2'd1;
	localparam logic [1:0] MODE_RELEASE = 2'd2;
	localparam logic [1:0] MODE_TICK    = 2'd3;

	// result status codes
	localparam logic [2:0] ST_INIT    = 3'd0;
	localparam logic [2:0] ST_GRANT   = 3'd1;
	localparam logic [2:0] ST_BADSEM  = 3'd2;
	localparam logic [2:0] ST_BUSY    = 3'd3;
	localparam logic [2:0] ST_QUEUED  = 3'd4;
	localparam logic [2:0] ST_FULL    = 3'd5;
	localparam logic [2:0] ST_FREE    = 3'd6;
	localparam logic [2:0] ST_TIMEOUT = 3'd7;

	// controller -> datapath
	typedef struct packed {
		logic                 load;  // latch the accepted request
		logic                 scan;  // process slot idx this cycle
		logic                 fin;   // commit the request and push its final result
		logic [SLOT_BITS-1:0] idx;   // slot under scan
	} tfs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_tick;   // latched request is a tick
		logic expire;    // slot idx times out on this tick
		logic pend_v;    // a timed-out result is held back
		logic out_free;  // output register can take a result now
	} tfs_stat_t;

endpackage

[design/tfs_ctrl.sv]
// ----------------------------------------------------------------------------
// tfs_ctrl
// Sequencer: accept a request, walk the waiter slots once, then finish.
// ----------------------------------------------------------------------------
module tfs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tfs_pkg::tfs_stat_t stat,
	output tfs_pkg::tfs_cmd_t  cmd
);
	import tfs_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(MAX_WAITERS - 1);

	logic [1:0]           state_q;
	logic [SLOT_BITS-1:0] idx_q;
	logic                 stall;
	logic                 fin_go;

	// a second expiry must wait until the held one can leave
	assign stall  = stat.is_tick && stat.expire && stat.pend_v && !stat.out_free;
	// tick with nothing expired finishes silently
	assign fin_go = stat.out_free || (stat.is_tick && !stat.pend_v);

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd      = '0;
		cmd.idx  = idx_q;
		cmd.load = in_valid && (state_q == S_IDLE);
		cmd.scan = (state_q == S_SCAN) && !stall;
		cmd.fin  = (state_q == S_FIN) && fin_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCAN;
						idx_q   <= '0;
					end
				end
				S_SCAN: begin
					if (!stall) begin
						if (idx_q == LAST_SLOT) begin
							state_q <= S_FIN;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[design/tfs_dp.sv]
// ----------------------------------------------------------------------------
// tfs_dp
// Semaphore and waiter-slot state, per-slot scan actions, result register.
// ----------------------------------------------------------------------------
module tfs_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tfs_pkg::tfs_cmd_t                     cmd,
	output tfs_pkg::tfs_stat_t                    stat,
	input  logic [1:0]                            mode,
	input  logic [tfs_pkg::SEM_BITS-1:0]          sem_index,
	input  logic [tfs_pkg::TASK_BITS-1:0]         task_id,
	input  logic signed [tfs_pkg::WT_BITS-1:0]    wait_ticks,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [2:0]                            status,
	output logic [tfs_pkg::TASK_BITS-1:0]         out_task,
	output logic [tfs_pkg::SEM_BITS-1:0]          out_sem,
	output logic                                  last
);
	import tfs_pkg::*;

	// latched request
	logic [1:0]           mode_q;
	logic [SEM_BITS-1:0]  sem_q;
	logic [TASK_BITS-1:0] task_q;
	logic [WT_BITS-1:0]   wt_q;

	// semaphore bank
	logic [NUM_SEMS-1:0]  sem_ready_q;
	logic [NUM_SEMS-1:0]  sem_held_q;
	logic [TASK_BITS-1:0] holder_q [NUM_SEMS];

	// waiter pool
	logic [MAX_WAITERS-1:0] slot_used_q;
	logic [TASK_BITS-1:0]   slot_task_q    [MAX_WAITERS];
	logic [SEM_BITS-1:0]    slot_sem_q     [MAX_WAITERS];
	logic                   slot_timed_q   [MAX_WAITERS];
	logic [TICK_BITS-1:0]   slot_ticks_q   [MAX_WAITERS];
	logic [ARR_BITS-1:0]    slot_arrival_q [MAX_WAITERS];
	logic [ARR_BITS-1:0]    arr_cnt_q;

	// scan accumulators
	logic                 free_v_q;
	logic [SLOT_BITS-1:0] free_idx_q;
	logic                 best_v_q;
	logic [SLOT_BITS-1:0] best_idx_q;
	logic [ARR_BITS-1:0]  best_age_q;
	logic [TASK_BITS-1:0] best_task_q;
	logic                 pend_v_q;
	logic [TASK_BITS-1:0] pend_task_q;
	logic [SEM_BITS-1:0]  pend_sem_q;

	// result register
	logic                 out_valid_q;
	logic [2:0]           status_q;
	logic [TASK_BITS-1:0] out_task_q;
	logic [SEM_BITS-1:0]  out_sem_q;
	logic                 last_q;

	// current slot view
	logic                 cur_used;
	logic                 cur_timed;
	logic                 cur_match;
	logic [ARR_BITS-1:0]  cur_age;
	logic [TICK_BITS-1:0] tick_dec;
	logic                 expire;
	logic                 out_free;

	// strobes
	logic is_init, is_acq, is_rel, is_tick;
	logic cur_ready, cur_held;
	logic init_clr, acq_find, rel_upd, tick_wr, tick_exp;
	logic acq_enq, acq_grant, rel_hand, rel_free, init_fin;
	logic push_scan, push_fin;

	// final result
	logic [2:0]           fin_status;
	logic [TASK_BITS-1:0] fin_task;
	logic [SEM_BITS-1:0]  fin_sem;
	logic                 fin_push;

	assign is_init   = (mode_q == MODE_INIT);
	assign is_acq    = (mode_q == MODE_ACQUIRE);
	assign is_rel    = (mode_q == MODE_RELEASE);
	assign is_tick   = (mode_q == MODE_TICK);
	assign cur_ready = sem_ready_q[sem_q];
	assign cur_held  = sem_held_q[sem_q];

	assign cur_used  = slot_used_q[cmd.idx];
	assign cur_timed = slot_timed_q[cmd.idx];
	assign cur_match = cur_used && (slot_sem_q[cmd.idx] == sem_q);
	assign cur_age   = arr_cnt_q - slot_arrival_q[cmd.idx];
	assign tick_dec  = (slot_ticks_q[cmd.idx] == '0) ? '0 : slot_ticks_q[cmd.idx] - 1'b1;
	assign expire    = is_tick && cur_used && cur_timed && (tick_dec == '0);
	assign out_free  = !out_valid_q || out_ready;

	assign init_clr = cmd.scan && is_init && cur_match;
	assign acq_find = cmd.scan && is_acq && !cur_used && !free_v_q;
	assign rel_upd  = cmd.scan && is_rel && cur_match && (!best_v_q || (cur_age > best_age_q));
	assign tick_wr  = cmd.scan && is_tick && cur_used && cur_timed;
	assign tick_exp = cmd.scan && expire;

	assign init_fin  = cmd.fin && is_init;
	assign acq_grant = cmd.fin && is_acq && cur_ready && !cur_held;
	assign acq_enq   = cmd.fin && is_acq && cur_ready && cur_held && (wt_q != '0) && free_v_q;
	assign rel_hand  = cmd.fin && is_rel && cur_ready && best_v_q;
	assign rel_free  = cmd.fin && is_rel && cur_ready && !best_v_q;

	assign push_scan = tick_exp && pend_v_q;
	assign push_fin  = cmd.fin && fin_push;

	always_comb begin
		fin_status = ST_INIT;
		fin_task   = '0;
		fin_sem    = sem_q;
		fin_push   = 1'b1;
		unique case (mode_q)
			MODE_INIT: begin
				fin_status = ST_INIT;
			end
			MODE_ACQUIRE: begin
				fin_task = task_q;
				if (!cur_ready) begin
					fin_status = ST_BADSEM;
					fin_task   = '0;
				end else if (!cur_held) begin
					fin_status = ST_GRANT;
				end else if (wt_q == '0) begin
					fin_status = ST_BUSY;
				end else if (!free_v_q) begin
					fin_status = ST_FULL;
				end else begin
					fin_status = ST_QUEUED;
				end
			end
			MODE_RELEASE: begin
				if (!cur_ready) begin
					fin_status = ST_BADSEM;
				end else if (best_v_q) begin
					fin_status = ST_GRANT;
					fin_task   = best_task_q;
				end else begin
					fin_status = ST_FREE;
				end
			end
			MODE_TICK: begin
				fin_status = ST_TIMEOUT;
				fin_task   = pend_task_q;
				fin_sem    = pend_sem_q;
				fin_push   = pend_v_q;
			end
			default: begin
				fin_push = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sem_ready_q <= '0;
			sem_held_q  <= '0;
			for (int s = 0; s < NUM_SEMS; s++) begin
				holder_q[s] <= '0;
			end
			slot_used_q <= '0;
			arr_cnt_q   <= '0;
			free_v_q    <= 1'b0;
			best_v_q    <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				free_v_q <= 1'b0;
				best_v_q <= 1'b0;
				pend_v_q <= 1'b0;
			end
			if (init_clr || tick_exp) begin
				slot_used_q[cmd.idx] <= 1'b0;
			end
			if (acq_find) begin
				free_v_q <= 1'b1;
			end
			if (rel_upd) begin
				best_v_q <= 1'b1;
			end
			if (tick_exp) begin
				pend_v_q <= 1'b1;
			end
			if (cmd.fin && is_tick) begin
				pend_v_q <= 1'b0;
			end
			if (init_fin) begin
				sem_ready_q[sem_q] <= 1'b1;
				sem_held_q[sem_q]  <= 1'b0;
				holder_q[sem_q]    <= '0;
			end
			if (acq_grant) begin
				sem_held_q[sem_q] <= 1'b1;
				holder_q[sem_q]   <= task_q;
			end
			if (acq_enq) begin
				slot_used_q[free_idx_q] <= 1'b1;
				arr_cnt_q               <= arr_cnt_q + 1'b1;
			end
			if (rel_hand) begin
				slot_used_q[best_idx_q] <= 1'b0;
				sem_held_q[sem_q]       <= 1'b1;
				holder_q[sem_q]         <= best_task_q;
			end
			if (rel_free) begin
				sem_held_q[sem_q] <= 1'b0;
				holder_q[sem_q]   <= '0;
			end
			if (push_scan || push_fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			sem_q  <= sem_index;
			task_q <= task_id;
			wt_q   <= wait_ticks;
		end
		if (acq_find) begin
			free_idx_q <= cmd.idx;
		end
		if (rel_upd) begin
			best_idx_q  <= cmd.idx;
			best_age_q  <= cur_age;
			best_task_q <= slot_task_q[cmd.idx];
		end
		if (tick_wr) begin
			slot_ticks_q[cmd.idx] <= tick_dec;
		end
		if (tick_exp) begin
			pend_task_q <= slot_task_q[cmd.idx];
			pend_sem_q  <= slot_sem_q[cmd.idx];
		end
		if (acq_enq) begin
			slot_task_q[free_idx_q]    <= task_q;
			slot_sem_q[free_idx_q]     <= sem_q;
			slot_timed_q[free_idx_q]   <= !wt_q[WT_BITS-1];
			slot_ticks_q[free_idx_q]   <= wt_q[WT_BITS-1] ? '0 : wt_q[TICK_BITS-1:0];
			slot_arrival_q[free_idx_q] <= arr_cnt_q;
		end
		if (push_scan) begin
			status_q   <= ST_TIMEOUT;
			out_task_q <= pend_task_q;
			out_sem_q  <= pend_sem_q;
			last_q     <= 1'b0;
		end else if (push_fin) begin
			status_q   <= fin_status;
			out_task_q <= fin_task;
			out_sem_q  <= fin_sem;
			last_q     <= 1'b1;
		end
	end

	assign stat.is_tick  = is_tick;
	assign stat.expire   = expire;
	assign stat.pend_v   = pend_v_q;
	assign stat.out_free = out_free;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_task  = out_task_q;
	assign out_sem   = out_sem_q;
	assign last      = last_q;

endmodule

[design/timed_fifo_semaphore.sv]
// ----------------------------------------------------------------------------
// timed_fifo_semaphore
// Bank of binary semaphores sharing a pool of timed FIFO waiter slots.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_ready | mode, sem_index, task_id, wait_ticks
//  out     | out_valid/out_ready | status, out_task, out_sem, last
//
//  Every request passes through an accept in idle, a scan of all MAX_WAITERS
//  waiter slots (one waiter slot per cycle through the slot register file,
//  unless the scan stalls) and a finish that waits for room in the result register.
//  A tick holds back each timed-out result by one so that last can be set on
//  the final one; a further expiry stalls the scan until out_ready frees room.
//  Reset (arst_n low) empties the pool and marks all semaphores uninitialized.
// ----------------------------------------------------------------------------
module timed_fifo_semaphore (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          mode,
	input  logic [tfs_pkg::SEM_BITS-1:0]        sem_index,
	input  logic [tfs_pkg::TASK_BITS-1:0]       task_id,
	input  logic signed [tfs_pkg::WT_BITS-1:0]  wait_ticks,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          status,
	output logic [tfs_pkg::TASK_BITS-1:0]       out_task,
	output logic [tfs_pkg::SEM_BITS-1:0]        out_sem,
	output logic                                last
);
	import tfs_pkg::*;

	tfs_cmd_t  cmd;
	tfs_stat_t stat;

	// sequencer: idle -> scan all slots -> finish
	tfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// state, per-slot actions and the result register
	tfs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.mode       (mode),
		.sem_index  (sem_index),
		.task_id    (task_id),
		.wait_ticks (wait_ticks),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_task   (out_task),
		.out_sem    (out_sem),
		.last       (last)
	);

`ifndef SYNTHESIS
	// one request at a time: after an accept the block is busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while previous one in flight");

	// finishing a request always returns to idle
	a_idle_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> in_ready)
		else $error("controller did not return to idle after finish");

	// no held-back timeout survives into idle
	a_no_pending_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.pend_v)
		else $error("timed-out result lost at end of tick");

	// scan and finish are exclusive
	a_scan_fin_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.scan && cmd.fin))
		else $error("scan and finish issued together");
`endif

endmodule

[tb/sv/sem_bank_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sem_bank_checker
// Watches both channels of the semaphore bank. It keeps a shadow copy of the
// owners, the waiter pool and the arrival stamps, works out the results of
// each accepted request and compares every accepted result with the oldest
// one still open.
// ----------------------------------------------------------------------------
module sem_bank_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic [1:0]                           mode,
	input  logic [tfs_pkg::SEM_BITS-1:0]         sem_index,
	input  logic [tfs_pkg::TASK_BITS-1:0]        task_id,
	input  logic signed [tfs_pkg::WT_BITS-1:0]   wait_ticks,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic [2:0]                           status,
	input  logic [tfs_pkg::TASK_BITS-1:0]        out_task,
	input  logic [tfs_pkg::SEM_BITS-1:0]         out_sem,
	input  logic                                 last,
	output int                                   mismatch_count,
	output int                                   outcomes_open,
	output int                                   outcomes_checked
);
	import tfs_pkg::*;

	typedef struct packed {
		logic [2:0]           status;
		logic [TASK_BITS-1:0] owner;
		logic [SEM_BITS-1:0]  sem;
		logic                 last;
	} outcome_t;

	// shadow of the bank
	logic [NUM_SEMS-1:0]    sem_ready;
	logic [NUM_SEMS-1:0]    sem_held;
	logic [TASK_BITS-1:0]   holder [NUM_SEMS];
	logic [MAX_WAITERS-1:0] slot_used;
	logic [MAX_WAITERS-1:0] slot_timed;
	logic [TASK_BITS-1:0]   slot_owner [MAX_WAITERS];
	logic [SEM_BITS-1:0]    slot_sem [MAX_WAITERS];
	logic [TICK_BITS-1:0]   slot_ticks [MAX_WAITERS];
	logic [ARR_BITS-1:0]    slot_stamp [MAX_WAITERS];
	logic [ARR_BITS-1:0]    arrival;

	outcome_t pending_outcomes[$];

	task automatic push_outcome(input logic [2:0] st, input logic [TASK_BITS-1:0] who,
			input logic [SEM_BITS-1:0] sem, input logic fin);
		outcome_t o;
		o.status = st;
		o.owner  = who;
		o.sem    = sem;
		o.last   = fin;
		pending_outcomes.push_back(o);
	endtask

	// the index field cannot exceed the bank here, so no out-of-range branch
	task automatic apply_semaphore_request(input logic [1:0] op,
			input logic [SEM_BITS-1:0] sem, input logic [TASK_BITS-1:0] tid,
			input logic signed [WT_BITS-1:0] wt);
		logic [MAX_WAITERS-1:0] expiring;
		logic [ARR_BITS-1:0]    age;
		logic [ARR_BITS-1:0]    oldest_age;
		int                     oldest;
		int                     free_slot;
		expiring   = '0;
		oldest     = -1;
		oldest_age = '0;
		free_slot  = -1;
		if (op == MODE_TICK) begin
			for (int i = 0; i < MAX_WAITERS; i++) begin
				if (slot_used[i] && slot_timed[i]) begin
					if (slot_ticks[i] != '0)
						slot_ticks[i] = slot_ticks[i] - 1'b1;
					if (slot_ticks[i] == '0) begin
						expiring[i]  = 1'b1;
						slot_used[i] = 1'b0;
					end
				end
			end
			// last goes on the highest expiring slot
			for (int i = 0; i < MAX_WAITERS; i++)
				if (expiring[i])
					push_outcome(ST_TIMEOUT, slot_owner[i], slot_sem[i],
						(expiring >> (i + 1)) == '0);
		end else if (op == MODE_INIT) begin
			sem_ready[sem] = 1'b1;
			sem_held[sem]  = 1'b0;
			holder[sem]    = '0;
			for (int i = 0; i < MAX_WAITERS; i++)
				if (slot_used[i] && slot_sem[i] == sem)
					slot_used[i] = 1'b0;
			push_outcome(ST_INIT, '0, sem, 1'b1);
		end else if (!sem_ready[sem]) begin
			push_outcome(ST_BADSEM, '0, sem, 1'b1);
		end else if (op == MODE_ACQUIRE) begin
			if (!sem_held[sem]) begin
				sem_held[sem] = 1'b1;
				holder[sem]   = tid;
				push_outcome(ST_GRANT, tid, sem, 1'b1);
			end else if (wt == '0) begin
				push_outcome(ST_BUSY, tid, sem, 1'b1);
			end else begin
				for (int i = MAX_WAITERS - 1; i >= 0; i--)
					if (!slot_used[i])
						free_slot = i;
				if (free_slot < 0) begin
					push_outcome(ST_FULL, tid, sem, 1'b1);
				end else begin
					// sign bit set: wait forever, whatever the magnitude
					slot_used[free_slot]  = 1'b1;
					slot_owner[free_slot] = tid;
					slot_sem[free_slot]   = sem;
					slot_timed[free_slot] = !wt[WT_BITS-1];
					slot_ticks[free_slot] = wt[WT_BITS-1] ? '0 : wt[TICK_BITS-1:0];
					slot_stamp[free_slot] = arrival;
					arrival = arrival + 1'b1;
					push_outcome(ST_QUEUED, tid, sem, 1'b1);
				end
			end
		end else begin
			// release: oldest stamp wins, ties to the lowest slot
			for (int i = 0; i < MAX_WAITERS; i++) begin
				if (slot_used[i] && slot_sem[i] == sem) begin
					age = arrival - slot_stamp[i];
					if (oldest < 0 || age > oldest_age) begin
						oldest     = i;
						oldest_age = age;
					end
				end
			end
			if (oldest >= 0) begin
				slot_used[oldest] = 1'b0;
				sem_held[sem]     = 1'b1;
				holder[sem]       = slot_owner[oldest];
				push_outcome(ST_GRANT, slot_owner[oldest], sem, 1'b1);
			end else begin
				sem_held[sem] = 1'b0;
				holder[sem]   = '0;
				push_outcome(ST_FREE, '0, sem, 1'b1);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t seen;
		outcome_t want;
		if (!arst_n) begin
			sem_ready  = '0;
			sem_held   = '0;
			slot_used  = '0;
			slot_timed = '0;
			arrival    = '0;
			for (int i = 0; i < NUM_SEMS; i++)
				holder[i] = '0;
			for (int i = 0; i < MAX_WAITERS; i++) begin
				slot_owner[i] = '0;
				slot_sem[i]   = '0;
				slot_ticks[i] = '0;
				slot_stamp[i] = '0;
			end
			pending_outcomes.delete();
			mismatch_count   = 0;
			outcomes_checked = 0;
		end else begin
			if (in_valid && in_ready)
				apply_semaphore_request(mode, sem_index, task_id, wait_ticks);
			if (out_valid && out_ready) begin
				seen.status = status;
				seen.owner  = out_task;
				seen.sem    = out_sem;
				seen.last   = last;
				if (pending_outcomes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result status %0d task %0d sem %0d last %0d",
							$realtime, seen.status, seen.owner, seen.sem, seen.last);
				end else begin
					want = pending_outcomes.pop_front();
					outcomes_checked++;
					if (seen.status !== want.status || seen.owner !== want.owner ||
							seen.sem !== want.sem || seen.last !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("%0t: result mismatch: expected status %0d task %0d sem %0d last %0d",
								$realtime, want.status, want.owner, want.sem, want.last);
							$display("%0t:                  got status %0d task %0d sem %0d last %0d",
								$realtime, seen.status, seen.owner, seen.sem, seen.last);
						end
					end
				end
			end
		end
		outcomes_open = pending_outcomes.size();
	end

endmodule

[tb/sv/timed_fifo_semaphore_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timed_fifo_semaphore_test
// Drives init, acquire, release and tick requests into the semaphore bank:
// a directed opening that walks through the corner cases, then random
// traffic in three handshake pressure phases. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module timed_fifo_semaphore_test;
	import tfs_pkg::*;

	localparam int CYCLE_LIMIT  = 200_000;  // far above the slowest legal run
	localparam int DRAIN_CYCLES = 40;       // idle time after the last result, to catch stray outputs

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [1:0]                mode;
	logic [SEM_BITS-1:0]       sem_index;
	logic [TASK_BITS-1:0]      task_id;
	logic signed [WT_BITS-1:0] wait_ticks;
	logic                      out_valid;
	logic                      out_ready;
	logic [2:0]                status;
	logic [TASK_BITS-1:0]      out_task;
	logic [SEM_BITS-1:0]       out_sem;
	logic                      last;

	int mismatch_count;
	int outcomes_open;
	int outcomes_checked;
	int send_idle;      // percent of cycles the request side holds back
	int recv_idle;      // percent of cycles the result side stalls
	int cycles;
	int op_count [4];   // requests sent, per operation

	always #6 clk = ~clk;

	timed_fifo_semaphore i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.sem_index  (sem_index),
		.task_id    (task_id),
		.wait_ticks (wait_ticks),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_task   (out_task),
		.out_sem    (out_sem),
		.last       (last)
	);

	sem_bank_checker i_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.sem_index        (sem_index),
		.task_id          (task_id),
		.wait_ticks       (wait_ticks),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.out_task         (out_task),
		.out_sem          (out_sem),
		.last             (last),
		.mismatch_count   (mismatch_count),
		.outcomes_open    (outcomes_open),
		.outcomes_checked (outcomes_checked)
	);

	// result side: ready is redrawn every falling edge
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("run stopped: cycle limit reached with %0d results open", outcomes_open);
			$display("Verification failed");
			$finish;
		end
	end

	// Entered and left at a falling edge. A gap drops valid for whole cycles;
	// with no gap valid stays high straight into the next request.
	task automatic send_request(input logic [1:0] op, input logic [SEM_BITS-1:0] sem,
			input logic [TASK_BITS-1:0] tid, input logic signed [WT_BITS-1:0] wt);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= op;
		sem_index  <= sem;
		task_id    <= tid;
		wait_ticks <= wt;
		op_count[op]++;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Random traffic. Acquires outnumber releases so the pool fills up and
	// queue-full and multi-expiry ticks show up; timeouts are mostly short
	// so ticks actually expire waiters.
	task automatic run_phase(input int n, input int s_idle, input int r_idle);
		int                        pick;
		logic [1:0]                op;
		logic signed [WT_BITS-1:0] wt;
		send_idle = s_idle;
		recv_idle = r_idle;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 6)
				op = MODE_INIT;
			else if (pick < 50)
				op = MODE_ACQUIRE;
			else if (pick < 75)
				op = MODE_RELEASE;
			else
				op = MODE_TICK;
			pick = $urandom_range(99);
			if (pick < 15)
				wt = '0;
			else if (pick < 35)
				wt = {1'b1, TICK_BITS'($urandom)};          // wait forever
			else if (pick < 85)
				wt = WT_BITS'($urandom_range(6, 1));
			else
				wt = {1'b0, TICK_BITS'($urandom)};          // long, rarely expires
			send_request(op, SEM_BITS'($urandom_range(NUM_SEMS - 1)),
				TASK_BITS'($urandom_range(255)), wt);
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mode       = MODE_INIT;
		sem_index  = '0;
		task_id    = '0;
		wait_ticks = '0;
		out_ready  = 1'b0;
		cycles     = 0;
		send_idle  = 20;
		recv_idle  = 86;
		foreach (op_count[i])
			op_count[i] = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed opening, slow receiver ---
		// nothing initialized yet: bad semaphore, and a tick with no waiters
		send_request(MODE_ACQUIRE, 2'd0, 8'h00, '0);
		send_request(MODE_RELEASE, 2'd3, 8'h00, '0);
		send_request(MODE_TICK,    2'd0, 8'h00, '0);
		for (int s = 0; s < NUM_SEMS; s++)
			send_request(MODE_INIT, SEM_BITS'(s), 8'hFF, '1);
		// grant, then busy on a zero timeout
		send_request(MODE_ACQUIRE, 2'd0, 8'hFF, '0);
		send_request(MODE_ACQUIRE, 2'd0, 8'h11, '0);
		// holder queues behind itself; forever, max ticks, most negative value
		send_request(MODE_ACQUIRE, 2'd0, 8'hFF, WT_BITS'(3));
		send_request(MODE_ACQUIRE, 2'd0, 8'h22, '1);
		send_request(MODE_ACQUIRE, 2'd0, 8'h33, {1'b0, {TICK_BITS{1'b1}}});
		send_request(MODE_ACQUIRE, 2'd0, 8'h44, {1'b1, {TICK_BITS{1'b0}}});
		// four one-tick waiters on sem 1 fill the pool, the next is refused
		send_request(MODE_ACQUIRE, 2'd1, 8'h55, '0);
		send_request(MODE_ACQUIRE, 2'd1, 8'h66, WT_BITS'(1));
		send_request(MODE_ACQUIRE, 2'd1, 8'h77, WT_BITS'(1));
		send_request(MODE_ACQUIRE, 2'd1, 8'h88, WT_BITS'(1));
		send_request(MODE_ACQUIRE, 2'd1, 8'h99, WT_BITS'(1));
		send_request(MODE_ACQUIRE, 2'd1, 8'hAA, WT_BITS'(2));
		// four expiries in one tick
		send_request(MODE_TICK,    2'd2, 8'h00, '0);
		// hand-over in arrival order, init drops the rest silently, then free
		send_request(MODE_RELEASE, 2'd0, 8'h00, '0);
		send_request(MODE_RELEASE, 2'd0, 8'h00, '0);
		send_request(MODE_INIT,    2'd0, 8'h00, '0);
		send_request(MODE_RELEASE, 2'd0, 8'h00, '0);
		send_request(MODE_RELEASE, 2'd1, 8'h00, '0);

		// --- random traffic in three pressure phases ---
		run_phase(75, 20, 86);
		run_phase(100, 86, 20);
		run_phase(100, 0, 0);
		in_valid <= 1'b0;

		// let the last results drain, then give the block time for strays
		while (outcomes_open != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d requests: %0d init, %0d acquire, %0d release, %0d tick",
			op_count[MODE_INIT] + op_count[MODE_ACQUIRE] + op_count[MODE_RELEASE] +
			op_count[MODE_TICK], op_count[MODE_INIT], op_count[MODE_ACQUIRE],
			op_count[MODE_RELEASE], op_count[MODE_TICK]);
		$display("%0d results checked across slow-sender, slow-receiver and full-rate phases",
			outcomes_checked);
		if (mismatch_count == 0 && outcomes_open == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d bad results, %0d expected results never seen",
				mismatch_count, outcomes_open);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
